// ===== rtl/ipv6tap_pkg.sv =====
// ============================================================================
// ipv6tap_pkg
// Types and character constants for the IPv6 text address parser.
// ============================================================================
package ipv6tap_pkg;

  // Parse phase of the running text
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_PLAIN   = 3'd1,
    PH_BRACKET = 3'd2,
    PH_SKIP    = 3'd3,
    PH_PORT    = 3'd4,
    PH_IGNORE  = 3'd5
  } phase_t;

  localparam int unsigned NUM_GROUPS = 8;

  localparam logic [7:0] CH_COLON   = 8'h3A;  // ':'
  localparam logic [7:0] CH_OPEN    = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE   = 8'h5D;  // ']'
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'

  localparam logic [15:0] HI_BYTE_MASK = 16'hFF00;
  localparam logic [15:0] LO_BYTE_MASK = 16'h00FF;

  // Complete running parse state
  typedef struct packed {
    logic [NUM_GROUPS-1:0][15:0] front;       // front groups, index = group number
    logic [NUM_GROUPS-1:0][15:0] back;        // back groups, newest at top index
    logic [3:0]                  front_count; // saturates at 15
    logic [3:0]                  back_count;  // saturates at 15
    logic [15:0]                 group_accum;
    logic                        in_back_part;
    logic                        prev_was_colon;
    phase_t                      phase;
    logic [15:0]                 port_accum;
  } parse_state_t;

endpackage

// ===== rtl/ipv6_text_address_parser.sv =====
// ============================================================================
// ipv6_text_address_parser
// Parses IPv6 address text, one character per transfer, into a 128-bit
// address, an optional decimal port and a malformed flag.
// ============================================================================
// One character is taken per clock cycle, continuously, as long as the result
// side keeps up. Each character is held in the input register, is folded into
// the running parse state by a single pass of logic, and on the character
// flagged by s_tlast the finished result is loaded into the output register:
// a last character passes through the input register and then the output
// register before its result is offered.
// The back part of the address is held as a shift line whose newest group
// sits at the bottom of the address, so the final address is a plain OR of
// the front and back group registers. The input stalls only while a result
// waits in the output register and the next registered character is itself
// a last character.
module ipv6_text_address_parser (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] character
  input  logic         s_tlast,   // last_char
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // [63:0] address_high, [127:64] address_low,
                                  // [143:128] port_number
  output logic         m_tuser    // [0] malformed
);

  // Input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // Running parse state
  ipv6tap_pkg::parse_state_t st;
  ipv6tap_pkg::parse_state_t st_next;
  ipv6tap_pkg::parse_state_t st_reset;

  logic         out_free;
  logic         process;
  logic         bad;
  logic [4:0]   count_sum;
  logic [127:0] address;
  logic [63:0]  addr_hi;
  logic [63:0]  addr_lo;

  // Close the current group into the front or back part
  function automatic ipv6tap_pkg::parse_state_t close_group(
    input ipv6tap_pkg::parse_state_t s
  );
    ipv6tap_pkg::parse_state_t r;
    r = s;
    if (s.in_back_part) begin
      if (s.back_count < 4'd8) begin
        for (int k = 0; k < ipv6tap_pkg::NUM_GROUPS - 1; k++) begin
          r.back[k] = s.back[k+1];
        end
        r.back[ipv6tap_pkg::NUM_GROUPS-1] = s.group_accum;
      end
      if (s.back_count < 4'd15) begin
        r.back_count = s.back_count + 4'd1;
      end
    end else begin
      if (s.front_count < 4'd8) begin
        r.front[s.front_count[2:0]] = s.group_accum;
      end
      if (s.front_count < 4'd15) begin
        r.front_count = s.front_count + 4'd1;
      end
    end
    r.group_accum = 16'd0;
    return r;
  endfunction

  // Feed one address character: colon closes a group, anything else is a digit
  function automatic ipv6tap_pkg::parse_state_t address_char(
    input ipv6tap_pkg::parse_state_t s,
    input logic [7:0]                c
  );
    ipv6tap_pkg::parse_state_t r;
    logic [15:0] a;
    r = s;
    if (c == ipv6tap_pkg::CH_COLON) begin
      if (s.prev_was_colon) begin
        r.in_back_part = 1'b1;
      end
      r = close_group(r);
      r.prev_was_colon = 1'b1;
    end else begin
      a = {s.group_accum[11:0], 4'd0} + {8'd0, c} - {8'd0, ipv6tap_pkg::CH_ZERO};
      if (c >= ipv6tap_pkg::CH_UPPER_A) begin
        a = a - 16'd7;
      end
      if (c >= ipv6tap_pkg::CH_LOWER_A) begin
        a = a - 16'd32;
      end
      r.group_accum    = a;
      r.prev_was_colon = 1'b0;
    end
    return r;
  endfunction

  // Handshake: a registered character advances unless its result has no room
  assign out_free = !m_tvalid || m_tready;
  assign process  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || process;

  // Capture the incoming character
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Reset value of the parse state
  always_comb begin
    st_reset                = '0;
    st_reset.phase          = ipv6tap_pkg::PH_START;
  end

  // Fold the registered character into the parse state
  always_comb begin
    st_next = st;
    case (st.phase)
      ipv6tap_pkg::PH_START: begin
        if (in_char == ipv6tap_pkg::CH_OPEN) begin
          st_next.phase = ipv6tap_pkg::PH_BRACKET;
        end else if (in_char == ipv6tap_pkg::CH_CLOSE) begin
          st_next       = close_group(st);
          st_next.phase = ipv6tap_pkg::PH_IGNORE;
        end else begin
          st_next       = address_char(st, in_char);
          st_next.phase = ipv6tap_pkg::PH_PLAIN;
        end
      end
      ipv6tap_pkg::PH_PLAIN, ipv6tap_pkg::PH_BRACKET: begin
        if (in_char == ipv6tap_pkg::CH_CLOSE) begin
          st_next       = close_group(st);
          st_next.phase = (st.phase == ipv6tap_pkg::PH_BRACKET) ?
                          ipv6tap_pkg::PH_SKIP : ipv6tap_pkg::PH_IGNORE;
        end else begin
          st_next = address_char(st, in_char);
        end
      end
      ipv6tap_pkg::PH_SKIP: begin
        st_next.phase = ipv6tap_pkg::PH_PORT;
      end
      ipv6tap_pkg::PH_PORT: begin
        st_next.port_accum = {st.port_accum[12:0], 3'd0} + {st.port_accum[14:0], 1'b0}
                           + {8'd0, in_char} - {8'd0, ipv6tap_pkg::CH_ZERO};
      end
      default: begin
        st_next = st;
      end
    endcase
    // Close the trailing group when the text ends inside the address
    if (in_last && (st_next.phase == ipv6tap_pkg::PH_START ||
                    st_next.phase == ipv6tap_pkg::PH_PLAIN ||
                    st_next.phase == ipv6tap_pkg::PH_BRACKET)) begin
      st_next = close_group(st_next);
    end
  end

  // Assemble the address: front and back parts never overlap when well formed
  assign count_sum = {1'b0, st_next.front_count} + {1'b0, st_next.back_count};
  assign bad       = count_sum > 5'd8;

  always_comb begin
    address = '0;
    for (int i = 0; i < ipv6tap_pkg::NUM_GROUPS; i++) begin
      address[127 - 16*i -: 16] =
        ((st_next.front[i] | st_next.back[i]) & ipv6tap_pkg::HI_BYTE_MASK) |
        ((st_next.front[i] | st_next.back[i]) & ipv6tap_pkg::LO_BYTE_MASK);
    end
  end

  assign addr_hi = bad ? 64'd0 : address[127:64];
  assign addr_lo = bad ? 64'd0 : address[63:0];

  // Advance the parse state, back to reset after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset;
    end else if (process) begin
      st <= in_last ? st_reset : st_next;
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (process && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && in_last) begin
      m_tdata <= {st_next.port_accum, addr_lo, addr_hi};
      m_tuser <= bad;
    end
  end

endmodule
